// ===== hdl/hcsb_pkg.sv =====
// Package: shared types, codes and the hex digit decoder of the hex colon string parser.
`timescale 1ns / 1ps
`default_nettype none

package hcsb_pkg;

	// Register map
	localparam int unsigned APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_BYTES = 3'd0;
	localparam logic [7:0] MAX_BYTES_RST = 8'd6;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] LC_BASE  = CH_LC_A - 8'd10;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_COLON  = 3'b100
	} phase_t;

	// Completion status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_LONG    = 2'd2
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one character as a hex digit of either case
	function automatic hex_t hex_decode(input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] dv;
		logic [7:0] lv;
		hex_t       h;
		lc = c | CASE_BIT;
		dv = c - CH_ZERO;
		lv = lc - LC_BASE;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			h.ok  = 1'b1;
			h.val = dv[3:0];
		end else if (lc >= CH_LC_A && lc <= CH_LC_F) begin
			h.ok  = 1'b1;
			h.val = lv[3:0];
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hex_colon_string_to_bytes.sv =====
// Top level: streaming parser of colon separated hex strings into bytes.
`timescale 1ns / 1ps
`default_nettype none

// Takes one character per transfer on ch and turns groups of one or two hex
// digits (either case, optionally followed by a colon) into bytes on the
// result channel. A zero character ends the string with status ok; a bad
// character ends it with invalid; characters beyond max_bytes bytes end it
// with too-long. Bytes already delivered stay delivered. Every ending rearms
// the parser with the byte budget reloaded from max_bytes; a write to
// max_bytes takes effect at the next rearm. One character is accepted every
// cycle unless a character with a result is held while the previous result
// waits; a result passes the input register, then the result register, and
// the result register lets the next character in while the previous result
// waits. Characters that complete no byte and end nothing give no result.
module hex_colon_string_to_bytes
	import hcsb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Character channel
	input  wire logic                  ch_valid,
	output logic                       ch_ready,
	input  wire logic [7:0]            ch,
	// Result channel
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic [7:0]                 byte_value,
	output logic                       byte_valid,
	output logic                       finished,
	output logic [1:0]                 status,
	// Configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [7:0] max_bytes_q;
	phase_t     phase_q;
	logic [3:0] high_nibble_q;
	logic [7:0] bytes_left_q;

	logic       vld_s1;
	logic [7:0] ch_s1;

	logic       res_valid_s2;
	logic [7:0] res_byte_s2;
	logic       res_bvld_s2;
	logic       res_fin_s2;
	status_t    res_status_s2;

	hex_t       hx;
	logic       is_colon;
	logic       is_nul;
	logic       emit;
	logic       e_byte;
	logic       e_fin;
	status_t    e_status;
	logic [7:0] e_val;
	phase_t     phase_d;
	logic [3:0] high_nibble_d;
	logic [7:0] bytes_left_d;
	logic       s1_adv;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_BYTES) begin
			max_bytes_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_MAX_BYTES) begin
			prdata = {24'd0, max_bytes_q};
		end
	end

	// Decode the registered character and work out the next state
	always_comb begin
		hx            = hex_decode(ch_s1);
		is_colon      = (ch_s1 == CH_COLON);
		is_nul        = (ch_s1 == CH_NUL);
		emit          = 1'b0;
		e_byte        = 1'b0;
		e_fin         = 1'b0;
		e_status      = ST_OK;
		e_val         = 8'd0;
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		bytes_left_d  = bytes_left_q;
		if (phase_q == PH_SECOND) begin
			if (hx.ok || is_colon || is_nul) begin
				emit   = 1'b1;
				e_byte = 1'b1;
				e_val  = hx.ok ? {high_nibble_q, hx.val} : {4'd0, high_nibble_q};
				if (bytes_left_q != 8'd0) begin
					bytes_left_d = bytes_left_q - 8'd1;
				end
				if (is_nul) begin
					e_fin = 1'b1;
				end else begin
					phase_d = PH_COLON;
				end
			end else begin
				emit     = 1'b1;
				e_fin    = 1'b1;
				e_status = ST_INVALID;
			end
		end else if (phase_q == PH_COLON && is_colon) begin
			// Skip the optional colon
			phase_d = PH_FIRST;
		end else begin
			phase_d = PH_FIRST;
			if (is_nul) begin
				emit  = 1'b1;
				e_fin = 1'b1;
			end else if (bytes_left_q == 8'd0) begin
				emit     = 1'b1;
				e_fin    = 1'b1;
				e_status = ST_LONG;
			end else if (!hx.ok) begin
				emit     = 1'b1;
				e_fin    = 1'b1;
				e_status = ST_INVALID;
			end else begin
				high_nibble_d = hx.val;
				phase_d       = PH_SECOND;
			end
		end
		// Rearm on every ending
		if (e_fin) begin
			phase_d       = PH_FIRST;
			high_nibble_d = 4'd0;
			bytes_left_d  = max_bytes_q;
		end
	end

	// Advance stage 1 when its result, if any, has room
	assign s1_adv   = vld_s1 && (!emit || !res_valid_s2 || res_ready);
	assign ch_ready = !vld_s1 || s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ch_ready) begin
			vld_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid && ch_ready) begin
			ch_s1 <= ch;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FIRST;
			high_nibble_q <= 4'd0;
			bytes_left_q  <= MAX_BYTES_RST;
		end else if (s1_adv) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_adv && emit) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_byte_s2   <= e_val;
			res_bvld_s2   <= e_byte;
			res_fin_s2    <= e_fin;
			res_status_s2 <= e_status;
		end
	end

	assign res_valid  = res_valid_s2;
	assign byte_value = res_byte_s2;
	assign byte_valid = res_bvld_s2;
	assign finished   = res_fin_s2;
	assign status     = res_status_s2;

	// Every result carries a byte or ends the string
	a_res_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (byte_valid || finished))
		else $error("result with neither byte nor finish");

	// A byte shares a result only with an ok ending
	a_byte_fin_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && byte_valid && finished) |-> (status == ST_OK))
		else $error("byte delivered with failing status");

	// An ending rearms the parser with the budget reloaded
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && e_fin) |=> (phase_q == PH_FIRST && high_nibble_q == 4'd0
			&& bytes_left_q == $past(max_bytes_q)))
		else $error("parser not rearmed after ending");

	// A non-final byte leaves the parser waiting for the optional colon
	a_byte_colon: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && e_byte && !e_fin) |=> (phase_q == PH_COLON))
		else $error("phase not advanced after byte");

endmodule

`default_nettype wire

// ===== tb/sv/hex_colon_string_to_bytes_tb.sv =====
// Testbench: random and directed hex string transfers checked against a built-in byte predictor.
`timescale 1ns / 1ps

import hcsb_pkg::*;

typedef struct packed {
	logic [7:0] value;
	logic       valid;
	logic       fin;
	status_t    st;
} parse_result_t;

// Predict the parser's results and check the ones the block delivers
class byte_scoreboard;
	parse_result_t pending_results[$];
	logic [7:0]    limit_bytes;
	phase_t        cur_phase;
	logic [3:0]    high_nib;
	logic [7:0]    bytes_left;
	int unsigned   errors;
	int unsigned   reports;

	function new();
		limit_bytes = MAX_BYTES_RST;
		errors = 0;
		reports = 0;
		restart();
	endfunction

	// New limit applies from the next rearm on
	function void set_limit(input logic [7:0] v);
		limit_bytes = v;
	endfunction

	function void restart();
		cur_phase = PH_FIRST;
		high_nib = 4'd0;
		bytes_left = limit_bytes;
	endfunction

	function int unsigned waiting();
		return pending_results.size();
	endfunction

	// Count a failure, print only the first ten
	function void report(input string msg);
		errors++;
		if (reports < 10) begin
			reports++;
			$display("[%0t] %s", $realtime, msg);
		end
	endfunction

	// Digits keep their low nibble; letters of either case add nine to it
	function bit digit_value(input logic [7:0] c, output logic [3:0] v);
		logic [7:0] folded;
		folded = c | CASE_BIT;
		v = 4'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = c[3:0];
			return 1'b1;
		end
		if (folded >= CH_LC_A && folded <= CH_LC_F) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the predicted parser by one character; return 1 when it yields a result
	function bit parse_char(input logic [7:0] c, output parse_result_t r);
		logic [3:0] nib;
		bit         is_hex;
		logic [7:0] val;
		r = '0;
		is_hex = digit_value(c, nib);
		if (cur_phase == PH_SECOND) begin
			if (is_hex) begin
				val = {high_nib, nib};
			end else if (c == CH_COLON || c == CH_NUL) begin
				val = {4'd0, high_nib};
			end else begin
				r.fin = 1'b1;
				r.st = ST_INVALID;
				restart();
				return 1'b1;
			end
			if (bytes_left != 8'd0)
				bytes_left = bytes_left - 8'd1;
			r.value = val;
			r.valid = 1'b1;
			if (c == CH_NUL) begin
				r.fin = 1'b1;
				r.st = ST_OK;
				restart();
			end else begin
				cur_phase = PH_COLON;
			end
			return 1'b1;
		end
		// Swallow the optional colon
		if (cur_phase == PH_COLON && c == CH_COLON) begin
			cur_phase = PH_FIRST;
			return 1'b0;
		end
		cur_phase = PH_FIRST;
		r.fin = 1'b1;
		if (c == CH_NUL) begin
			r.st = ST_OK;
		end else if (bytes_left == 8'd0) begin
			r.st = ST_LONG;
		end else if (!is_hex) begin
			r.st = ST_INVALID;
		end else begin
			high_nib = nib;
			cur_phase = PH_SECOND;
			return 1'b0;
		end
		restart();
		return 1'b1;
	endfunction

	function void note_char(input logic [7:0] c);
		parse_result_t r;
		if (parse_char(c, r))
			pending_results.push_back(r);
	endfunction

	function void check_result(input parse_result_t got);
		parse_result_t want;
		if (pending_results.size() == 0) begin
			report($sformatf("unexpected result: value=%02h valid=%0d fin=%0d status=%0d",
				got.value, got.valid, got.fin, got.st));
			return;
		end
		want = pending_results.pop_front();
		if (got.value !== want.value || got.valid !== want.valid ||
				got.fin !== want.fin || got.st !== want.st) begin
			report($sformatf({"result mismatch: expected value=%02h valid=%0d fin=%0d status=%0d,",
				" got value=%02h valid=%0d fin=%0d status=%0d"},
				want.value, want.valid, want.fin, want.st,
				got.value, got.valid, got.fin, got.st));
		end
	endfunction
endclass

module hex_colon_string_to_bytes_tb;

	localparam int unsigned PHASES       = 10;
	localparam int unsigned PHASE_ITEMS  = 123;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned TIMEOUT_NS   = 5_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  ch_valid = 1'b0;
	logic                  ch_ready;
	logic [7:0]            ch = 8'd0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic [7:0]            byte_value;
	logic                  byte_valid;
	logic                  finished;
	logic [1:0]            status;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = 32'd0;
	logic [31:0]           prdata;
	logic                  pready;

	byte_scoreboard sb = new();
	logic [7:0]     char_plan[$];
	logic [7:0]     max_setting = MAX_BYTES_RST;
	int unsigned    burst_left = 0;
	bit             hold_off_req = 1'b0;

	hex_colon_string_to_bytes u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch_valid   (ch_valid),
		.ch_ready   (ch_ready),
		.ch         (ch),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.byte_value (byte_value),
		.byte_valid (byte_valid),
		.finished   (finished),
		.status     (status),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	// Note each character transfer, then check each result transfer
	always @(posedge clk) begin
		parse_result_t got;
		if (arst_n) begin
			if (ch_valid && ch_ready)
				sb.note_char(ch);
			if (res_valid && res_ready) begin
				got.value = byte_value;
				got.valid = byte_valid;
				got.fin = finished;
				got.st = status_t'(status);
				sb.check_result(got);
			end
		end
	end

	// Stall the result channel in changing patterns; hold off on request
	initial begin : receiver
		int unsigned mode;
		int unsigned run;
		mode = 0;
		run = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				res_ready <= 1'b0;
				for (int k = 1; k < HOLD_CYCLES; k++)
					@(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (run == 0) begin
					mode = $urandom_range(3, 0);
					run = $urandom_range(200, 20);
				end
				run--;
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(1, 0));
					2: res_ready <= ($urandom_range(3, 0) == 0);
					default: res_ready <= ~res_ready;
				endcase
			end
		end
	end

	// Offer one character and wait for its transfer; insert gaps between bursts
	task automatic offer_char(input logic [7:0] c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap != 0) begin
				ch_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(40, 1);
		end
		burst_left--;
		ch <= c;
		ch_valid <= 1'b1;
		@(posedge clk);
		while (!ch_ready) @(posedge clk);
	endtask

	task automatic offer_text(input string s);
		for (int i = 0; i < s.len(); i++)
			offer_char(s[i]);
	endtask

	// Drop valid and wait until every predicted result has arrived
	task automatic settle();
		ch_valid <= 1'b0;
		@(posedge clk);
		while (sb.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write max_bytes, then read it back
	task automatic write_max_bytes(input logic [7:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_BYTES;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_limit(v);
		max_setting = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[7:0] !== v)
			sb.report($sformatf("max_bytes readback: expected %02h, got %02h", v, prdata[7:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] rand_hex();
		logic [7:0] v;
		v = 8'($urandom_range(15, 0));
		if (v < 8'd10)
			return CH_ZERO + v;
		if ($urandom_range(1, 0))
			return (CH_LC_A & ~CASE_BIT) + v - 8'd10;
		return CH_LC_A + v - 8'd10;
	endfunction

	// Plan one string: mostly well formed, sometimes too long, broken or trailed by noise
	function automatic void plan_string(input logic [7:0] limit);
		int unsigned n;
		int unsigned break_at;
		bit          broken;
		n = (limit > 8'd10) ? $urandom_range(10, 0) :
			($urandom_range(5, 0) == 0) ? limit + $urandom_range(2, 1) : $urandom_range(limit, 0);
		broken = ($urandom_range(7, 0) == 0);
		break_at = $urandom_range(n, 0);
		for (int i = 0; i < n; i++) begin
			if (broken && break_at == i)
				char_plan.push_back(8'($urandom_range(255, 1)));
			if ($urandom_range(2, 0) == 0) begin
				char_plan.push_back(rand_hex());
				if (i != n - 1 || $urandom_range(1, 0)) begin
					char_plan.push_back(CH_COLON);
					if ($urandom_range(1, 0))
						char_plan.push_back(CH_COLON);
				end
			end else begin
				char_plan.push_back(rand_hex());
				char_plan.push_back(rand_hex());
				if ((i != n - 1) ? ($urandom_range(3, 0) != 0) : ($urandom_range(3, 0) == 0))
					char_plan.push_back(CH_COLON);
			end
		end
		if (broken && break_at == n)
			char_plan.push_back(8'($urandom_range(255, 1)));
		char_plan.push_back(CH_NUL);
		if ($urandom_range(9, 0) == 0) begin
			repeat ($urandom_range(3, 1))
				char_plan.push_back(8'($urandom_range(255, 0)));
		end
	endfunction

	// End the run if it hangs
	initial begin
		#(TIMEOUT_NS);
		$display("hex_colon_string_to_bytes_tb NOT OK");
		$finish;
	end

	initial begin
		logic [7:0] lim;
		logic [7:0] fixed_limits[3];
		fixed_limits = '{8'd255, 8'd0, 8'd1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed strings at the reset limit
		offer_text("Ff:0A");
		offer_char(CH_NUL);
		offer_text("9::a");
		offer_char(CH_NUL);
		offer_text("7");
		offer_char(CH_NUL);
		offer_text("g");
		offer_text("a:1z");
		offer_char(CH_NUL);
		offer_char(8'hff);
		settle();
		// Limit of one: third digit is too long
		write_max_bytes(8'd1);
		offer_text("123");
		offer_char(CH_NUL);
		settle();
		// Limit of zero: any digit is too long
		write_max_bytes(8'd0);
		offer_text("5");
		offer_char(CH_NUL);
		settle();

		// Random phases, each under its own limit
		for (int p = 0; p < PHASES; p++) begin
			if (p < 3)
				lim = fixed_limits[p];
			else
				lim = ($urandom_range(8, 0) == 0) ? 8'd255 : 8'($urandom_range(8, 2));
			write_max_bytes(lim);
			char_plan.delete();
			while (char_plan.size() < PHASE_ITEMS)
				plan_string(max_setting);
			if (p == 4)
				hold_off_req = 1'b1;
			foreach (char_plan[i])
				offer_char(char_plan[i]);
			settle();
		end

		if (sb.errors == 0 && sb.waiting() == 0)
			$display("hex_colon_string_to_bytes_tb OK");
		else
			$display("hex_colon_string_to_bytes_tb NOT OK");
		$finish;
	end

endmodule
